// ----- rtl/flba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_pkg
// Shared constants, codes and types of the free list block allocator.
// ----------------------------------------------------------------------------
package flba_pkg;

   localparam int POOL_DEPTH = 256;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = 9;
   localparam int LINK_W     = IDX_W + 1;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] BC_RESET  = CNT_W'(POOL_DEPTH);

   // CSR map: one 32-bit register per word
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_BLOCK_COUNT = 1'b0;

   // request kinds
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;  // latch request, launch link read
      logic commit;   // update list state, load result register
   } flba_cmd_type;

endpackage

// ----- rtl/flba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module flba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/flba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_ctrl
// Request sequencer: accept, wait for link read, commit into result slot.
// ----------------------------------------------------------------------------
module flba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output flba_pkg::flba_cmd_type cmd
);
   import flba_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   // result slot can take a new transaction when empty or draining
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/flba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_dp
// Free list datapath: head, free count, link store, block count register.
// ----------------------------------------------------------------------------
module flba_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  flba_pkg::flba_cmd_type         cmd,
   input  logic                           req_mode,
   input  logic [flba_pkg::IDX_W-1:0]     req_block_index,
   input  logic                           cfg_wr_en,
   input  logic [flba_pkg::CNT_W-1:0]     cfg_wr_data,
   output logic [flba_pkg::CNT_W-1:0]     block_count,
   output logic [1:0]                     rsp_status,
   output logic [flba_pkg::IDX_W-1:0]     rsp_granted_index,
   output logic [flba_pkg::CNT_W-1:0]     rsp_free_count
);
   import flba_pkg::*;

   logic [CNT_W-1:0]      bc_ff, bc_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      free_ff, free_in;
   logic [POOL_DEPTH-1:0] vld_ff, vld_in;
   logic                  mode_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      hsel_ff;   // clamped head, address of the link read
   logic                  hvld_ff;   // link entry written since rebuild
   logic [1:0]            status_ff, status_in;
   logic [IDX_W-1:0]      grant_ff, grant_in;
   logic [CNT_W-1:0]      count_ff;

   logic [IDX_W-1:0]  hsel;
   logic [LINK_W-1:0] ram_q;
   logic [LINK_W-1:0] nxt;
   logic [CNT_W-1:0]  free_dec;
   logic              ram_we;
   logic [LINK_W-1:0] ram_wd;
   logic [CNT_W-1:0]  cfg_clamped;

   // corrupted head falls back to block 0
   assign hsel = ({1'b0, head_ff} >= bc_ff) ? '0 : head_ff;

   always_comb begin
      cfg_clamped = cfg_wr_data;
      if (cfg_wr_data == '0) begin
         cfg_clamped = CNT_W'(1);
      end else if (cfg_wr_data > BC_RESET) begin
         cfg_clamped = BC_RESET;
      end
   end

   // unwritten link entry reads as its rebuild value i+1
   assign nxt      = hvld_ff ? ram_q : ({1'b0, hsel_ff} + LINK_W'(1));
   assign free_dec = free_ff - CNT_W'(1);
   assign ram_wd   = (free_ff != '0) ? {1'b0, head_ff} : LINK_W'(bc_ff);

   always_comb begin
      bc_in     = bc_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      vld_in    = vld_ff;
      ram_we    = 1'b0;
      status_in = STATUS_OK;
      grant_in  = '0;
      if (cfg_wr_en) begin
         bc_in   = cfg_clamped;
         head_in = '0;
         free_in = cfg_clamped;
         vld_in  = '0;
      end else if (cmd.commit) begin
         if (mode_ff == MODE_ALLOC) begin
            if (free_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               grant_in = hsel_ff;
               free_in  = free_dec;
               if (free_dec != '0) begin
                  head_in = (nxt < LINK_W'(bc_ff)) ? nxt[IDX_W-1:0] : '0;
               end
            end
         end else begin
            if ({1'b0, idx_ff} >= bc_ff) begin
               status_in = STATUS_BAD_INDEX;
            end else begin
               ram_we         = 1'b1;
               vld_in[idx_ff] = 1'b1;
               head_in        = idx_ff;
               if (free_ff < COUNT_MAX) begin
                  free_in = free_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff   <= BC_RESET;
         head_ff <= '0;
         free_ff <= BC_RESET;
         vld_ff  <= '0;
      end else begin
         bc_ff   <= bc_in;
         head_ff <= head_in;
         free_ff <= free_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         idx_ff  <= req_block_index;
         hsel_ff <= hsel;
         hvld_ff <= vld_ff[hsel];
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         count_ff  <= free_in;
      end
   end

   flba_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wd),
      .rd_en   (cmd.capture),
      .rd_addr (hsel),
      .rd_data (ram_q)
   );

   assign block_count       = bc_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = grant_ff;
   assign rsp_free_count    = count_ff;

endmodule

// ----- rtl/free_list_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_block_allocator
// Fixed-size block pool kept as a singly linked free list in a link RAM.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_mode, req_block_index
//   rsp      out        rsp_valid/rsp_ready   rsp_status, rsp_granted_index,
//                                             rsp_free_count
//   csr      in/out     APB psel/penable      block_count at byte address 0
//
// Each transaction is accepted, then committed. The accept cycle
// launches the link RAM read at the head; its registered data sets the
// new head at commit. A new request is accepted only after the commit.
// Reset (synchronous, active high) sets block_count to 256, head to 0 and
// marks every link entry unwritten; these read as index + 1, needing no
// clearing pass. A block_count write does so too, value clamped to 1..256.
// Stalls: a finished result sits in the output register while the next
// request is accepted; commit waits only while that register is still full.
// ----------------------------------------------------------------------------
module free_list_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [flba_pkg::IDX_W-1:0]       req_block_index,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [flba_pkg::IDX_W-1:0]       rsp_granted_index,
   output logic [flba_pkg::CNT_W-1:0]       rsp_free_count,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [flba_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [flba_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [flba_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import flba_pkg::*;

   flba_cmd_type     cmd;
   logic             cfg_wr_en;
   logic [CNT_W-1:0] block_count;

   // Register index is the word address; only block_count exists.
   assign pready    = 1'b1;
   assign cfg_wr_en = psel && penable && pwrite && pready &&
                      (paddr[2] == CSR_IDX_BLOCK_COUNT);
   assign prdata    = (paddr[2] == CSR_IDX_BLOCK_COUNT) ?
                      CSR_DATA_W'(block_count) : '0;

   // Sequencer: owns the handshakes and the result-valid flag.
   flba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: list state, link RAM, result register.
   flba_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_mode          (req_mode),
      .req_block_index   (req_block_index),
      .cfg_wr_en         (cfg_wr_en),
      .cfg_wr_data       (pwdata[CNT_W-1:0]),
      .block_count       (block_count),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

// ----- bench/free_list_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_block_allocator_tb
// Self-checking bench for the free list block allocator. A tracker class
// keeps its own copy of the link store, head and free count, predicts the
// outcome of every accepted request and checks results in order. Stimulus
// is a directed opening, a double-free run that raises the free count
// above the block count, and random phases with mostly well-formed
// allocate/free traffic under several block counts and idle/stall mixes.
// ----------------------------------------------------------------------------
module free_list_block_allocator_tb;
   import flba_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // one expected result transaction
   typedef struct {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted;
      logic [CNT_W-1:0] count;
   } alloc_outcome_type;

   // Tracker: mirror of the pool state plus the queue of pending outcomes.
   class free_list_tracker_type;
      logic [LINK_W-1:0] next_link [POOL_DEPTH];
      logic [IDX_W-1:0]  head;
      logic [CNT_W-1:0]  free_cnt;
      logic [CNT_W-1:0]  blk_cnt;
      alloc_outcome_type outcome_q [$];
      int                error_count;

      function new();
         error_count = 0;
         load_block_count(32'(BC_RESET));
      endfunction

      // register write: clamp to 1..POOL_DEPTH and rebuild the list
      function void load_block_count(logic [31:0] raw);
         logic [CNT_W-1:0] v;
         int               i;
         v = raw[CNT_W-1:0];
         if (v == 0)
            v = CNT_W'(1);
         else if (v > POOL_DEPTH)
            v = CNT_W'(POOL_DEPTH);
         blk_cnt = v;
         for (i = 0; i < POOL_DEPTH; i++)
            next_link[i] = LINK_W'(i + 1);
         head     = '0;
         free_cnt = blk_cnt;
      endfunction

      function alloc_outcome_type note_request(logic mode, logic [IDX_W-1:0] idx);
         alloc_outcome_type o;
         logic [IDX_W-1:0]  h;
         logic [LINK_W-1:0] nxt;
         o.status  = STATUS_OK;
         o.granted = '0;
         if (mode == MODE_ALLOC) begin
            if (free_cnt == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               h = (head >= blk_cnt) ? '0 : head;
               o.granted = h;
               free_cnt  = free_cnt - 1'b1;
               // head holds when the pool runs dry
               if (free_cnt != 0) begin
                  nxt  = next_link[h];
                  head = (nxt < blk_cnt) ? nxt[IDX_W-1:0] : '0;
               end
            end
         end else if (idx >= blk_cnt) begin
            o.status = STATUS_BAD_INDEX;
         end else begin
            // push onto an empty pool links to the sentinel
            next_link[idx] = (free_cnt != 0) ? LINK_W'(head) : LINK_W'(blk_cnt);
            head = idx;
            if (free_cnt != COUNT_MAX)
               free_cnt = free_cnt + 1'b1;
         end
         o.count = free_cnt;
         outcome_q.push_back(o);
         return o;
      endfunction

      function void check_outcome(logic [1:0] status, logic [IDX_W-1:0] granted,
                                  logic [CNT_W-1:0] count);
         alloc_outcome_type o;
         if (outcome_q.size() == 0) begin
            $error("result transaction with nothing expected: status %0d index %0d count %0d",
                   status, granted, count);
            error_count++;
            return;
         end
         o = outcome_q.pop_front();
         if (status !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, status);
            error_count++;
         end
         if (granted !== o.granted) begin
            $error("granted_index: expected %0d, actual %0d", o.granted, granted);
            error_count++;
         end
         if (count !== o.count) begin
            $error("free_count: expected %0d, actual %0d", o.count, count);
            error_count++;
         end
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic                  req_mode        = MODE_ALLOC;
   logic [IDX_W-1:0]      req_block_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [1:0]            rsp_status;
   logic [IDX_W-1:0]      rsp_granted_index;
   logic [CNT_W-1:0]      rsp_free_count;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   free_list_block_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_free_count    (rsp_free_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   free_list_tracker_type tracker;
   logic [IDX_W-1:0] held_blocks [$];   // blocks handed out and not yet returned
   int               send_idle_pct = 0; // chance per cycle that the requester idles
   int               stall_pct     = 0; // chance per cycle that the receiver stalls
   int               cycle_count   = 0;

   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("free_list_block_allocator_tb NOT OK");
         $finish;
      end
   end

   // Receiver: ready changes on the falling edge, stalls per the current mix.
   always @(negedge clock) begin
      if (stall_pct == 0)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Result monitor: every accepted result goes to the tracker in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         tracker.check_outcome(rsp_status, rsp_granted_index, rsp_free_count);
   end

   // Send one request transaction. Valid goes up on a falling edge, stays up
   // until accepted, and is left up so a back-to-back item keeps it high.
   task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx);
      int                gap;
      alloc_outcome_type o;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
         gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_block_index <= idx;
      do @(posedge clock); while (req_ready !== 1'b1);
      o = tracker.note_request(mode, idx);
      if (mode == MODE_ALLOC && o.status == STATUS_OK)
         held_blocks.push_back(o.granted);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write of block_count: setup cycle, then access until pready.
   task automatic write_block_count(input logic [CSR_DATA_W-1:0] value);
      drain_results();
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {CSR_IDX_BLOCK_COUNT, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.load_block_count(value);
      held_blocks.delete();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random request mix: mostly well-formed alloc/free of held blocks,
   // plus double frees and out-of-range frees.
   task automatic send_random_request();
      int               r;
      int               pos;
      logic [IDX_W-1:0] idx;
      r   = $urandom_range(99);
      idx = IDX_W'($urandom);
      if (r < 45) begin
         send_request(MODE_ALLOC, idx);
      end else if (r < 85) begin
         if (held_blocks.size() == 0) begin
            send_request(MODE_ALLOC, idx);
         end else begin
            pos = $urandom_range(held_blocks.size() - 1);
            idx = held_blocks[pos];
            held_blocks.delete(pos);
            send_request(MODE_FREE, idx);
         end
      end else if (r < 93) begin
         // any in-range index, often already free
         send_request(MODE_FREE, IDX_W'($urandom_range(tracker.blk_cnt - 1)));
      end else begin
         send_request(MODE_FREE, idx);
      end
   endtask

   initial begin
      int                    p;
      int                    n;
      logic [CSR_DATA_W-1:0] cfg;
      tracker = new();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed: full pool after reset ---
      send_request(MODE_ALLOC, 8'hFF);            // grants 0
      send_request(MODE_ALLOC, 8'h00);            // grants 1
      send_request(MODE_FREE, 8'd0);
      send_request(MODE_ALLOC, 8'h5A);
      send_request(MODE_FREE, 8'd1);
      send_request(MODE_FREE, 8'd0);

      // single block pool: empty pool, bad index, sentinel link, double free
      write_block_count(32'd1);
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'hFF);            // pool empty
      send_request(MODE_FREE, 8'd1);              // index out of range
      send_request(MODE_FREE, 8'd255);            // index out of range
      send_request(MODE_FREE, 8'd0);              // push onto empty pool
      send_request(MODE_FREE, 8'd0);              // double free
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'h00);            // empty again

      // zero is taken as one block
      write_block_count(32'd0);
      send_request(MODE_FREE, 8'd0);
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'h00);

      // 0x3FF masks to 511, clamped to the full pool
      write_block_count(32'h0000_03FF);
      send_request(MODE_FREE, 8'd255);            // double free at the top index
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_ALLOC, 8'h00);
      send_request(MODE_FREE, 8'd128);

      // --- free count overrun: repeated frees on a full pool ---
      write_block_count(32'd256);
      for (n = 0; n < 270; n++) begin
         if ($urandom_range(9) == 0)
            send_request(MODE_ALLOC, IDX_W'($urandom));
         else
            send_request(MODE_FREE, IDX_W'($urandom));
      end

      // --- random phases: block count and idle mix change per phase ---
      for (p = 0; p < 8; p++) begin
         case (p)
            0:       cfg = 32'd2;
            1:       cfg = 32'd3;
            2:       cfg = 32'h0000_0200;          // masks to zero, one block
            3:       cfg = 32'($urandom_range(4, 16));
            4:       cfg = 32'd300;                // clamped to the full pool
            5:       cfg = 32'($urandom_range(1, 256));
            6:       cfg = 32'({$urandom, 9'd0}) | 32'($urandom_range(1, 64));
            default: cfg = 32'd256;
         endcase
         write_block_count(cfg);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct     = 13;
            end
         endcase
         for (n = 0; n < 110; n++)
            send_random_request();
      end

      // wait out the last results, then a few more cycles for strays
      drain_results();
      repeat (10) @(posedge clock);

      if (tracker.error_count == 0 && tracker.pending() == 0)
         $display("free_list_block_allocator_tb OK");
      else
         $display("free_list_block_allocator_tb NOT OK");
      $finish;
   end

endmodule
